// ===== hdl/grid_bucket_insertion_engine_defines.svh =====
// Assertion macros for the grid bucket insertion engine.
`ifndef GRID_BUCKET_INSERTION_ENGINE_DEFINES_SVH
`define GRID_BUCKET_INSERTION_ENGINE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define GBIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define GBIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/gbie_pkg.sv =====
// Package: constants, widths and operation codes of the grid bucket insertion engine.
package gbie_pkg;

  localparam int CELLS      = 4096;
  localparam int MAX_POINTS = 4096;

  // Field widths
  localparam int OP_W   = 2;
  localparam int CELL_W = 12;
  localparam int SLOT_W = 12;
  localparam int PNT_W  = 12;
  localparam int WIDE_W = 13;

  // Address widths of the tables and the width of the point counter
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PT_AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_SLOT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_CELL = 2'd2;

endpackage

// ===== hdl/gbie_if.sv =====
// Channel interfaces: request channel and result channel.
interface gbie_in_if;
  import gbie_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CELL_W-1:0] cell_number;
  logic [SLOT_W-1:0] slot_number;

  modport source (output valid, output operation, output cell_number, output slot_number,
                  input ready);
  modport sink   (input valid, input operation, input cell_number, input slot_number,
                  output ready);
endinterface

interface gbie_out_if;
  import gbie_pkg::*;

  logic              valid;
  logic              ready;
  logic [PNT_W-1:0]  point_number;
  logic [WIDE_W-1:0] cell_start;
  logic [WIDE_W-1:0] cell_count;
  logic              error_flag;

  modport source (output valid, output point_number, output cell_start, output cell_count,
                  output error_flag, input ready);
  modport sink   (input valid, input point_number, input cell_start, input cell_count,
                  input error_flag, output ready);
endinterface

// ===== hdl/grid_bucket_insertion_engine.sv =====
// Grid bucket insertion engine: per-cell point buckets kept in one packed list.
//
// Channels: in_ch carries requests (insert point, read list slot, read cell
// start/count); out_ch returns exactly one result per request. A transfer
// happens on a rising edge with valid and ready both high.
// in_ch.ready is high only while the sequencer is idle; one request is worked
// at a time. An output register holds the result, so the next request is
// taken while a result still waits for the receiver.
// Slot read and cell read: one read state, then ST_FINISH fills the output
// register. Insert: the cell's start and count are read, then the list
// entries from the new point's slot up to the last point held shift up one
// slot, one entry a cycle through the point memory, then the start offsets
// of all later cells go up by one, one cell a cycle through the start table
// memory. Refused requests (full store, bad cell, bad slot, unknown
// operation) go straight to ST_FINISH.
// Reset: a clearing pass over all CELLS (4096) entries zeroes the start and count
// tables; in_ch.ready stays low meanwhile. The point list is not cleared.
// Receiver stall: a finished result holds in the output register; the
// sequencer waits at the end of the next request until the register frees.
`include "grid_bucket_insertion_engine_defines.svh"

module grid_bucket_insertion_engine (
  input  logic        clk,
  input  logic        rst_n,
  gbie_in_if.sink     in_ch,
  gbie_out_if.source  out_ch
);
  import gbie_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_POS,
    ST_SHIFT,
    ST_START_UPD,
    ST_CELL_RD,
    ST_SLOT_RD,
    ST_FINISH
  } state_t;

  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);

  // Memories
  logic [PNT_W-1:0]  pt_mem_r [MAX_POINTS];
  logic [WIDE_W-1:0] st_mem_r [CELLS];
  logic [WIDE_W-1:0] ct_mem_r [CELLS];
  logic [PNT_W-1:0]  pt_rd_r;
  logic [WIDE_W-1:0] st_rd_r;
  logic [WIDE_W-1:0] ct_rd_r;

  logic              pt_re, pt_we;
  logic [PT_AW-1:0]  pt_ra, pt_wa;
  logic [PNT_W-1:0]  pt_wd;
  logic              st_re, st_we;
  logic [CELL_AW-1:0] st_ra, st_wa;
  logic [WIDE_W-1:0] st_wd;
  logic              ct_re, ct_we;
  logic [CELL_AW-1:0] ct_ra, ct_wa;
  logic [WIDE_W-1:0] ct_wd;

  // Sequencer state
  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               err_r, err_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [PT_AW-1:0]   pos_r, pos_nxt;
  logic [PT_AW-1:0]   sh_idx_r, sh_idx_nxt;
  logic [PT_AW-1:0]   sh_wa_r, sh_wa_nxt;
  logic [CELL_AW-1:0] su_idx_r, su_idx_nxt;
  logic [CELL_AW-1:0] su_wa_r, su_wa_nxt;
  logic [CELL_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic               rd_act_r, rd_act_nxt;
  logic               pend_r, pend_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PNT_W-1:0]   out_pnum_r, out_pnum_nxt;
  logic [WIDE_W-1:0]  out_start_r, out_start_nxt;
  logic [WIDE_W-1:0]  out_count_r, out_count_nxt;
  logic               out_err_r, out_err_nxt;

  logic               in_xfer;
  logic [WIDE_W:0]    run_end;
  logic [WIDE_W:0]    n_ext;
  logic [WIDE_W:0]    pos_full;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_xfer             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.point_number = out_pnum_r;
  assign out_ch.cell_start   = out_start_r;
  assign out_ch.cell_count   = out_count_r;
  assign out_ch.error_flag   = out_err_r;

  // End of the cell's run, clipped to the list fill
  assign run_end  = {1'b0, st_rd_r} + {1'b0, ct_rd_r};
  assign n_ext    = (WIDE_W + 1)'(n_r);
  assign pos_full = (run_end > n_ext) ? n_ext : run_end;

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem_r[pt_wa] <= pt_wd;
    if (pt_re) pt_rd_r <= pt_mem_r[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem_r[st_wa] <= st_wd;
    if (st_re) st_rd_r <= st_mem_r[st_ra];
  end

  always_ff @(posedge clk) begin
    if (ct_we) ct_mem_r[ct_wa] <= ct_wd;
    if (ct_re) ct_rd_r <= ct_mem_r[ct_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cell_nxt      = cell_r;
    slot_nxt      = slot_r;
    err_nxt       = err_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    sh_idx_nxt    = sh_idx_r;
    sh_wa_nxt     = sh_wa_r;
    su_idx_nxt    = su_idx_r;
    su_wa_nxt     = su_wa_r;
    clr_idx_nxt   = clr_idx_r;
    rd_act_nxt    = rd_act_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pnum_nxt  = out_pnum_r;
    out_start_nxt = out_start_r;
    out_count_nxt = out_count_r;
    out_err_nxt   = out_err_r;

    pt_re = 1'b0;
    pt_ra = sh_idx_r;
    pt_we = 1'b0;
    pt_wa = sh_wa_r;
    pt_wd = pt_rd_r;
    st_re = 1'b0;
    st_ra = cell_r[CELL_AW-1:0];
    st_we = 1'b0;
    st_wa = su_wa_r;
    st_wd = st_rd_r + 1'b1;
    ct_re = 1'b0;
    ct_ra = cell_r[CELL_AW-1:0];
    ct_we = 1'b0;
    ct_wa = cell_r[CELL_AW-1:0];
    ct_wd = ct_rd_r + 1'b1;

    case (state_r)
      ST_CLEAR: begin
        st_we = 1'b1;
        st_wa = clr_idx_r;
        st_wd = '0;
        ct_we = 1'b1;
        ct_wa = clr_idx_r;
        ct_wd = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_CELL) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt   = in_ch.operation;
          cell_nxt = in_ch.cell_number;
          slot_nxt = in_ch.slot_number;
          err_nxt  = 1'b0;
          case (in_ch.operation)
            OP_INSERT: begin
              if (n_r >= MAX_POINTS || in_ch.cell_number >= CELLS) begin
                err_nxt   = 1'b1;
                state_nxt = ST_FINISH;
              end else begin
                state_nxt = ST_INS_RD;
              end
            end
            OP_READ_SLOT: begin
              if (in_ch.slot_number < n_r && in_ch.slot_number < MAX_POINTS) begin
                state_nxt = ST_SLOT_RD;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = ST_FINISH;
              end
            end
            OP_READ_CELL: begin
              if (in_ch.cell_number < CELLS) begin
                state_nxt = ST_CELL_RD;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = ST_FINISH;
              end
            end
            default: begin
              err_nxt   = 1'b1;
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        st_re     = 1'b1;
        ct_re     = 1'b1;
        state_nxt = ST_INS_POS;
      end
      ST_INS_POS: begin
        ct_we      = 1'b1;
        pos_nxt    = pos_full[PT_AW-1:0];
        pend_nxt   = 1'b0;
        rd_act_nxt = (n_ext > pos_full);
        sh_idx_nxt = PT_AW'(n_r - 1'b1);
        state_nxt  = ST_SHIFT;
      end
      ST_SHIFT: begin
        // read slot i while the entry read last cycle goes to slot i+2
        pt_re     = rd_act_r;
        pt_ra     = sh_idx_r;
        pt_we     = pend_r;
        pt_wa     = sh_wa_r;
        pt_wd     = pt_rd_r;
        pend_nxt  = rd_act_r;
        sh_wa_nxt = sh_idx_r + 1'b1;
        if (rd_act_r) begin
          if (sh_idx_r == pos_r) rd_act_nxt = 1'b0;
          else                   sh_idx_nxt = sh_idx_r - 1'b1;
        end
        if (!rd_act_r && !pend_r) begin
          pt_we      = 1'b1;
          pt_wa      = pos_r;
          pt_wd      = PNT_W'(n_r);
          rd_act_nxt = (cell_r[CELL_AW-1:0] != LAST_CELL);
          su_idx_nxt = cell_r[CELL_AW-1:0] + 1'b1;
          state_nxt  = ST_START_UPD;
        end
      end
      ST_START_UPD: begin
        st_re     = rd_act_r;
        st_ra     = su_idx_r;
        st_we     = pend_r;
        st_wa     = su_wa_r;
        st_wd     = st_rd_r + 1'b1;
        pend_nxt  = rd_act_r;
        su_wa_nxt = su_idx_r;
        if (rd_act_r) begin
          if (su_idx_r == LAST_CELL) rd_act_nxt = 1'b0;
          else                       su_idx_nxt = su_idx_r + 1'b1;
        end
        if (!rd_act_r && !pend_r) begin
          n_nxt     = n_r + 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_CELL_RD: begin
        st_re     = 1'b1;
        ct_re     = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_SLOT_RD: begin
        pt_re     = 1'b1;
        pt_ra     = slot_r[PT_AW-1:0];
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_pnum_nxt  = (op_r == OP_READ_SLOT && !err_r) ? pt_rd_r : '0;
          out_start_nxt = (op_r == OP_READ_CELL && !err_r) ? st_rd_r : '0;
          out_count_nxt = (op_r == OP_READ_CELL && !err_r) ? ct_rd_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      n_r         <= '0;
      rd_act_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      n_r         <= n_nxt;
      rd_act_r    <= rd_act_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    cell_r      <= cell_nxt;
    slot_r      <= slot_nxt;
    err_r       <= err_nxt;
    pos_r       <= pos_nxt;
    sh_idx_r    <= sh_idx_nxt;
    sh_wa_r     <= sh_wa_nxt;
    su_idx_r    <= su_idx_nxt;
    su_wa_r     <= su_wa_nxt;
    out_pnum_r  <= out_pnum_nxt;
    out_start_r <= out_start_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
  end

  // Assertions
  `GBIE_ASSERT(a_fill_bound, n_r <= MAX_POINTS, "point count beyond store size")
  `GBIE_ASSERT(a_fill_step, ($past(rst_n) && n_r != $past(n_r)) |-> (n_r == $past(n_r) + 1'b1), "point count moved by more than one")
  `GBIE_ASSERT(a_shift_above_pos, (state_r == ST_SHIFT && pend_r) |-> (sh_wa_r > pos_r), "list shift writes at or below insert slot")
  `GBIE_ASSERT(a_err_payload, (out_valid_r && out_err_r) |-> (out_pnum_r == '0 && out_start_r == '0 && out_count_r == '0), "refused request carries payload")
  `GBIE_ASSERT_ALWAYS(a_busy_clear, (state_r == ST_CLEAR) |-> !in_xfer, "request taken during table clear")

endmodule
